// ===== rtl/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants of the annotation skip parser
// Phase codes, frame layout, stack commands, fail codes and tag decoding.
// ----------------------------------------------------------------------------
package asp_pkg;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_TYPE    = 4'd1,
		PH_PAIRCNT = 4'd2,
		PH_NAME    = 4'd3,
		PH_TAG     = 4'd4,
		PH_SKIP2   = 4'd5,
		PH_SKIP4   = 4'd6,
		PH_ARRCNT  = 4'd7
	} asp_phase_t;

	typedef enum logic [1:0] {
		FR_NONE     = 2'd0,
		FR_BAD_TAG  = 2'd1,
		FR_NO_BYTES = 2'd2,
		FR_TOO_DEEP = 2'd3
	} asp_reason_t;

	typedef enum logic [2:0] {
		TK_CONST,
		TK_ENUM,
		TK_ARRAY,
		TK_ANNOT,
		TK_BAD
	} asp_tag_kind_t;

	// One open frame: list kind and the number of elements still to start.
	typedef struct packed {
		logic        pairs;
		logic [15:0] left;
	} asp_frame_t;

	localparam int FRAME_W = $bits(asp_frame_t);

	typedef struct packed {
		logic       clear;
		logic       push;
		logic       pop;
		logic       dec;
		asp_frame_t frame;
	} asp_stack_cmd_t;

	typedef struct packed {
		logic       empty;
		logic       full;
		asp_frame_t top;
	} asp_stack_sts_t;

	localparam logic [7:0] TAG_BYTE    = 8'h42; // 'B'
	localparam logic [7:0] TAG_CHAR    = 8'h43; // 'C'
	localparam logic [7:0] TAG_INT     = 8'h49; // 'I'
	localparam logic [7:0] TAG_SHORT   = 8'h53; // 'S'
	localparam logic [7:0] TAG_DOUBLE  = 8'h44; // 'D'
	localparam logic [7:0] TAG_FLOAT   = 8'h46; // 'F'
	localparam logic [7:0] TAG_LONG    = 8'h4A; // 'J'
	localparam logic [7:0] TAG_BOOL    = 8'h5A; // 'Z'
	localparam logic [7:0] TAG_CLASS   = 8'h63; // 'c'
	localparam logic [7:0] TAG_STRING  = 8'h73; // 's'
	localparam logic [7:0] TAG_ENUM    = 8'h65; // 'e'
	localparam logic [7:0] TAG_ARRAY   = 8'h5B; // '['
	localparam logic [7:0] TAG_ANNOT   = 8'h40; // '@'

	function automatic asp_tag_kind_t asp_tag_kind(input logic [7:0] b);
		asp_tag_kind_t k;
		case (b)
			TAG_BYTE, TAG_CHAR, TAG_INT, TAG_SHORT, TAG_DOUBLE,
			TAG_FLOAT, TAG_LONG, TAG_BOOL, TAG_CLASS, TAG_STRING: k = TK_CONST;
			TAG_ENUM:  k = TK_ENUM;
			TAG_ARRAY: k = TK_ARRAY;
			TAG_ANNOT: k = TK_ANNOT;
			default:   k = TK_BAD;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/asp_ram.sv =====
// ----------------------------------------------------------------------------
// asp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module asp_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/asp_frame_stack.sv =====
// ----------------------------------------------------------------------------
// asp_frame_stack: stack of open frames
// Top frame lives in a register; deeper frames spill to a RAM and refill
// the top register from it after a pop, through the registered RAM read.
// ----------------------------------------------------------------------------
module asp_frame_stack #(
	parameter int MAX_DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  asp_pkg::asp_stack_cmd_t cmd,
	output asp_pkg::asp_stack_sts_t sts
);
	import asp_pkg::*;

	localparam int LVL_W = $clog2(MAX_DEPTH + 1);
	localparam int AW    = $clog2(MAX_DEPTH);

	logic [LVL_W-1:0]   level_q;
	logic               reload_q;
	asp_frame_t         top_q;
	logic [LVL_W-1:0]   lvl_m1;
	logic [LVL_W-1:0]   lvl_m2;
	logic [FRAME_W-1:0] rdata;
	logic               spill;

	assign lvl_m1 = level_q - LVL_W'(1);
	assign lvl_m2 = level_q - LVL_W'(2);
	assign spill  = cmd.push && (level_q != '0);

	// Spill the old top on push; fetch the new top on pop.
	asp_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(MAX_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (spill),
		.waddr(lvl_m1[AW-1:0]),
		.wdata(top_q),
		.raddr(lvl_m2[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			reload_q <= 1'b0;
		end else if (cmd.clear) begin
			level_q  <= '0;
			reload_q <= 1'b0;
		end else if (cmd.push) begin
			level_q  <= level_q + LVL_W'(1);
			reload_q <= 1'b0;
		end else if (cmd.pop) begin
			level_q  <= lvl_m1;
			reload_q <= (level_q > LVL_W'(1));
		end else begin
			reload_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= cmd.frame;
		end else if (cmd.dec) begin
			top_q.left <= top_q.left - 16'd1;
		end else if (reload_q) begin
			top_q <= asp_frame_t'(rdata);
		end
	end

	assign sts.empty = (level_q == '0);
	assign sts.full  = (level_q == LVL_W'(MAX_DEPTH));
	assign sts.top   = top_q;

endmodule

// ===== rtl/annotation_skip_parser_unit.sv =====
// ----------------------------------------------------------------------------
// annotation_skip_parser_unit: byte-serial class-file annotation skipper
// Walks one annotation byte per transaction and reports its end position,
// or the limit position with a fail code.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte is parsed from the input stage once the result
//   register is free; results are registered (one register stage each side).
// Throughput: one byte per cycle while the result side is not stalled; the
//   parse step, the top frame register and one stack RAM port set that rate.
// Reset: arst_n clears control state asynchronously; the frame stack RAM is
//   not cleared (entries are read only after being written), no sweep needed.
// ----------------------------------------------------------------------------
module annotation_skip_parser_unit #(
	parameter int MAX_DEPTH     = 64,
	parameter int POSITION_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte transactions in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic [30:0] start_pos,
	input  logic [30:0] limit_pos,
	// result transactions out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] end_pos,
	output logic        failed,
	output logic [1:0]  fail_reason
);
	import asp_pkg::*;

	localparam int PW = POSITION_BITS;

	// Input stage
	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          first_s1;
	logic [30:0]   start_s1;
	logic [30:0]   limit_s1;

	// Parser state
	asp_phase_t    phase_q;
	logic [1:0]    fbi_q;
	logic [7:0]    cnt_hi_q;
	logic [PW-1:0] cur_pos_q;
	logic [PW-1:0] lim_pos_q;

	// Result register
	logic          out_valid_q;
	logic [30:0]   end_pos_q;
	logic          failed_q;
	asp_reason_t   reason_q;

	// Stack interface
	asp_stack_cmd_t cmd;
	asp_stack_sts_t sts;

	// Decode
	logic          proceed;
	asp_phase_t    ph_eff;
	logic [1:0]    fbi_eff;
	logic [7:0]    cnt_hi_eff;
	logic [PW-1:0] cur_eff;
	logic [PW-1:0] lim_eff;
	logic [PW-1:0] cur_inc;
	logic          empty_eff;
	logic          full_eff;
	logic          oob;
	logic          act;
	logic          pairs;
	logic [15:0]   cnt;
	logic          cnt_done;
	logic          cnt_zero;
	logic          cnt_multi;
	logic          deep;
	asp_tag_kind_t tag_kind;
	logic          bad_tag;
	logic          skip_done;
	logic          vdone;
	logic          finish;
	logic          next_elem;
	logic          last_of_top;

	// Next state
	asp_phase_t    phase_d;
	logic [1:0]    fbi_d;
	logic [7:0]    cnt_hi_d;

	// Result
	logic          emit;
	logic [PW-1:0] res_pos;
	asp_reason_t   res_reason;

	// ------------------------------------------------------------------
	// Handshake: the parse step runs when a byte waits in the input stage
	// and the result register is free or being drained this cycle.
	// ------------------------------------------------------------------
	assign proceed  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage: hold while stalled.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			start_s1 <= start_pos;
			limit_s1 <= limit_pos;
		end
	end

	// ------------------------------------------------------------------
	// Decode: apply a restart first, then classify what this byte does.
	// ------------------------------------------------------------------
	always_comb begin
		if (first_s1) begin
			ph_eff     = PH_TYPE;
			fbi_eff    = 2'd0;
			cnt_hi_eff = 8'd0;
			cur_eff    = PW'(start_s1);
			lim_eff    = PW'(limit_s1);
			empty_eff  = 1'b1;
			full_eff   = 1'b0;
		end else begin
			ph_eff     = phase_q;
			fbi_eff    = fbi_q;
			cnt_hi_eff = cnt_hi_q;
			cur_eff    = cur_pos_q;
			lim_eff    = lim_pos_q;
			empty_eff  = sts.empty;
			full_eff   = sts.full;
		end

		cur_inc  = cur_eff + PW'(1);
		// A byte at or past the limit runs the annotation out of bytes.
		oob      = (ph_eff != PH_IDLE) && (cur_eff >= lim_eff);
		act      = (ph_eff != PH_IDLE) && !oob;

		pairs    = (ph_eff == PH_PAIRCNT);
		cnt      = {cnt_hi_eff, data_s1};
		cnt_done = act && (ph_eff == PH_PAIRCNT || ph_eff == PH_ARRCNT) && (fbi_eff == 2'd1);
		cnt_zero = (cnt == 16'd0);
		cnt_multi = (cnt > 16'd1);
		// Only a frame with work left after its first element takes a slot.
		deep     = cnt_done && cnt_multi && full_eff;

		tag_kind = asp_tag_kind(data_s1);
		bad_tag  = act && (ph_eff == PH_TAG) && (tag_kind == TK_BAD);

		skip_done = act && (((ph_eff == PH_SKIP2) && (fbi_eff >= 2'd1)) ||
			((ph_eff == PH_SKIP4) && (fbi_eff == 2'd3)));

		vdone     = skip_done || (cnt_done && cnt_zero);
		finish    = vdone && empty_eff;
		next_elem = vdone && !empty_eff;
		// Pop the top frame as soon as its last element starts.
		last_of_top = (sts.top.left == 16'd1);
	end

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		phase_d  = ph_eff;
		fbi_d    = fbi_eff;
		cnt_hi_d = cnt_hi_eff;

		if (oob) begin
			phase_d = PH_IDLE;
			fbi_d   = 2'd0;
		end else if (act) begin
			case (ph_eff)
				PH_TYPE, PH_NAME: begin
					if (fbi_eff == 2'd0) begin
						fbi_d = 2'd1;
					end else begin
						fbi_d   = 2'd0;
						phase_d = (ph_eff == PH_TYPE) ? PH_PAIRCNT : PH_TAG;
					end
				end
				PH_PAIRCNT, PH_ARRCNT: begin
					if (fbi_eff == 2'd0) begin
						cnt_hi_d = data_s1;
						fbi_d    = 2'd1;
					end else begin
						fbi_d = 2'd0;
						if (deep) begin
							phase_d = PH_IDLE;
						end else if (!cnt_zero) begin
							phase_d = pairs ? PH_NAME : PH_TAG;
						end
					end
				end
				PH_TAG: begin
					fbi_d = 2'd0;
					case (tag_kind)
						TK_CONST: phase_d = PH_SKIP2;
						TK_ENUM:  phase_d = PH_SKIP4;
						TK_ARRAY: phase_d = PH_ARRCNT;
						TK_ANNOT: phase_d = PH_TYPE;
						default:  phase_d = PH_IDLE;
					endcase
				end
				PH_SKIP2, PH_SKIP4: begin
					if (!skip_done) begin
						fbi_d = fbi_eff + 2'd1;
					end
				end
				default: phase_d = PH_IDLE;
			endcase

			// A finished value either ends the annotation or starts the
			// next element of the enclosing frame.
			if (finish) begin
				phase_d = PH_IDLE;
				fbi_d   = 2'd0;
			end else if (next_elem) begin
				phase_d = sts.top.pairs ? PH_NAME : PH_TAG;
				fbi_d   = 2'd0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Outputs of the parse step: result and stack command
	// ------------------------------------------------------------------
	always_comb begin
		emit = oob || bad_tag || deep || finish;

		if (oob) begin
			res_reason = FR_NO_BYTES;
		end else if (bad_tag) begin
			res_reason = FR_BAD_TAG;
		end else if (deep) begin
			res_reason = FR_TOO_DEEP;
		end else begin
			res_reason = FR_NONE;
		end
		res_pos = finish ? cur_inc : lim_eff;

		cmd.clear       = proceed && first_s1;
		cmd.push        = proceed && cnt_done && cnt_multi && !deep;
		cmd.pop         = proceed && next_elem && last_of_top;
		cmd.dec         = proceed && next_elem && !last_of_top;
		cmd.frame.pairs = pairs;
		cmd.frame.left  = cnt - 16'd1;
	end

	asp_frame_stack #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts)
	);

	// Advance parser state once per parsed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			fbi_q     <= 2'd0;
			cnt_hi_q  <= 8'd0;
			cur_pos_q <= '0;
			lim_pos_q <= '0;
		end else if (proceed) begin
			phase_q   <= phase_d;
			fbi_q     <= fbi_d;
			cnt_hi_q  <= cnt_hi_d;
			cur_pos_q <= act ? cur_inc : cur_eff;
			lim_pos_q <= lim_eff;
		end
	end

	// Result register: load on emit, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && emit) begin
			end_pos_q <= 31'(res_pos);
			failed_q  <= !finish;
			reason_q  <= res_reason;
		end
	end

	assign out_valid   = out_valid_q;
	assign end_pos     = end_pos_q;
	assign failed      = failed_q;
	assign fail_reason = reason_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fail_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (failed == (fail_reason != FR_NONE)))
		else $error("fail flag and fail code disagree");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.full)
		else $error("frame pushed onto a full stack");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && !first_s1 && phase_q == PH_IDLE) |->
			(!emit && !cmd.push && !cmd.pop && !cmd.dec))
		else $error("idle byte caused a result or stack change");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push, cmd.pop, cmd.dec}))
		else $error("more than one stack operation in a cycle");

	a_pop_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> !(cmd.push || cmd.pop || cmd.dec))
		else $error("stack used while its top frame refills");

endmodule

// ===== tb/annotation_skip_parser_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annotation_skip_parser_unit_test: self-checking bench for the annotation
// skipper
// Streams annotation bytes through the unit: short hand-built cases first,
// then random annotations. Most are well formed with random content; the rest
// are mutated, cut short, deeply nested or plain noise. A byte-level walker
// predicts each end position or fail code. Both handshakes idle and stall at
// random, with two long result-side hold-offs and a few drain pauses.
// ----------------------------------------------------------------------------
module annotation_skip_parser_unit_test;
	import asp_pkg::*;

	localparam int MAX_DEPTH     = 64;
	localparam int POSITION_BITS = 31;
	localparam int BYTE_TARGET   = 1650;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [30:0] end_pos;
		logic        failed;
		asp_reason_t reason;
	} walk_result_t;

	// One byte transaction as queued for the driver. The drain flag makes the
	// driver hold this byte back until every expected result has come.
	typedef struct {
		logic [7:0]  data;
		logic        first;
		logic [30:0] start;
		logic [30:0] limit;
		bit          drain;
	} byte_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic [30:0] start_pos;
	logic [30:0] limit_pos;
	logic        out_valid;
	logic        out_stall;
	logic [30:0] end_pos;
	logic        failed;
	logic [1:0]  fail_reason;

	annotation_skip_parser_unit #(
		.MAX_DEPTH(MAX_DEPTH),
		.POSITION_BITS(POSITION_BITS)
	) uut (.*);

	byte_item_t   byte_feed[$];      // bytes still to be offered, oldest first
	walk_result_t expected_ends[$];  // predicted results not yet seen
	logic [7:0]   seq_bytes[$];      // scratch for building one annotation

	int cycle_count    = 0;
	int mismatch_count = 0;
	int accepted_count = 0;
	bit taken          = 0;

	// ------------------------------------------------------------------------
	// Byte walker: mirrors the parse state of the unit one byte at a time.
	// ------------------------------------------------------------------------
	asp_phase_t  walk_phase  = PH_IDLE;
	logic [1:0]  field_idx   = '0;
	logic [7:0]  count_hi    = '0;
	asp_frame_t  frames [MAX_DEPTH];
	int unsigned depth_level = 0;
	logic [30:0] walk_pos    = '0;
	logic [30:0] walk_limit  = '0;

	// Finish the walk: go idle and hand back the result.
	function automatic walk_result_t close_walk(input logic [30:0] pos, input logic bad,
			input asp_reason_t why);
		walk_phase = PH_IDLE;
		field_idx  = '0;
		return '{end_pos: pos, failed: bad, reason: why};
	endfunction

	// One value is fully consumed: either the outer annotation is done, or
	// start the next element of the top frame, dropping the frame when that
	// element is its last one.
	function automatic bit value_complete(output walk_result_t r);
		asp_frame_t  top;
		logic [15:0] left;
		r = '0;
		if (depth_level == 0) begin
			r = close_walk(walk_pos, 1'b0, FR_NONE);
			return 1'b1;
		end
		top  = frames[depth_level - 1];
		left = top.left - 16'd1;
		if (left == 16'd0)
			depth_level--;
		else
			frames[depth_level - 1].left = left;
		walk_phase = top.pairs ? PH_NAME : PH_TAG;
		field_idx  = '0;
		return 1'b0;
	endfunction

	// Advance the walk by one accepted byte; returns 1 when a result is due.
	function automatic bit walk_annotation_byte(input byte_item_t it, output walk_result_t r);
		logic [15:0] n;
		logic        pairs;
		r = '0;
		if (it.first) begin
			walk_phase  = PH_TYPE;
			field_idx   = '0;
			count_hi    = '0;
			depth_level = 0;
			walk_pos    = it.start;
			walk_limit  = it.limit;
		end
		if (walk_phase == PH_IDLE)
			return 1'b0;
		if (walk_pos >= walk_limit) begin
			r = close_walk(walk_limit, 1'b1, FR_NO_BYTES);
			return 1'b1;
		end
		walk_pos = walk_pos + 31'd1;
		case (walk_phase)
			PH_TYPE, PH_NAME: begin
				if (field_idx == 2'd0) begin
					field_idx = 2'd1;
				end else begin
					field_idx  = 2'd0;
					walk_phase = (walk_phase == PH_TYPE) ? PH_PAIRCNT : PH_TAG;
				end
			end
			PH_PAIRCNT, PH_ARRCNT: begin
				if (field_idx == 2'd0) begin
					count_hi  = it.data;
					field_idx = 2'd1;
				end else begin
					field_idx = 2'd0;
					n         = {count_hi, it.data};
					pairs     = (walk_phase == PH_PAIRCNT);
					if (n == 16'd0)
						return value_complete(r);
					// a single element never needs a frame of its own
					if (n > 16'd1) begin
						if (depth_level >= MAX_DEPTH) begin
							r = close_walk(walk_limit, 1'b1, FR_TOO_DEEP);
							return 1'b1;
						end
						frames[depth_level] = {pairs, n - 16'd1};
						depth_level++;
					end
					walk_phase = pairs ? PH_NAME : PH_TAG;
				end
			end
			PH_TAG: begin
				field_idx = 2'd0;
				case (it.data)
					TAG_BYTE, TAG_CHAR, TAG_INT, TAG_SHORT, TAG_DOUBLE,
					TAG_FLOAT, TAG_LONG, TAG_BOOL, TAG_CLASS, TAG_STRING:
						walk_phase = PH_SKIP2;
					TAG_ENUM:  walk_phase = PH_SKIP4;
					TAG_ARRAY: walk_phase = PH_ARRCNT;
					TAG_ANNOT: walk_phase = PH_TYPE;
					default: begin
						r = close_walk(walk_limit, 1'b1, FR_BAD_TAG);
						return 1'b1;
					end
				endcase
			end
			PH_SKIP2, PH_SKIP4: begin
				if (field_idx >= ((walk_phase == PH_SKIP4) ? 2'd3 : 2'd1))
					return value_complete(r);
				field_idx = field_idx + 2'd1;
			end
			default: walk_phase = PH_IDLE;
		endcase
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Annotation builders: append bytes to seq_bytes.
	// ------------------------------------------------------------------------
	task automatic add_random(input int n);
		repeat (n) seq_bytes.push_back(8'($urandom));
	endtask

	task automatic add_count(input int n);
		seq_bytes.push_back(8'(n >> 8));
		seq_bytes.push_back(8'(n));
	endtask

	task automatic add_const();
		logic [7:0] tags [10];
		tags = '{TAG_BYTE, TAG_CHAR, TAG_INT, TAG_SHORT, TAG_DOUBLE,
			TAG_FLOAT, TAG_LONG, TAG_BOOL, TAG_CLASS, TAG_STRING};
		seq_bytes.push_back(tags[$urandom_range(9)]);
		add_random(2);
	endtask

	// Keep counts small, and smaller still deeper down, so sizes stay bounded.
	function automatic int pick_count(input int depth);
		int p;
		p = $urandom_range(99);
		if (p < 15)
			return 0;
		if (p < 45)
			return 1;
		return (depth >= 2) ? 2 : $urandom_range(2, 3);
	endfunction

	task automatic add_value(input int depth);
		int pick;
		int n;
		pick = $urandom_range(99);
		if (depth >= 3 && pick >= 60)
			pick = $urandom_range(59);
		if (pick < 45) begin
			add_const();
		end else if (pick < 60) begin
			seq_bytes.push_back(TAG_ENUM);
			add_random(4);
		end else if (pick < 80) begin
			seq_bytes.push_back(TAG_ARRAY);
			n = pick_count(depth);
			add_count(n);
			repeat (n) add_value(depth + 1);
		end else begin
			seq_bytes.push_back(TAG_ANNOT);
			add_annotation(depth + 1);
		end
	endtask

	task automatic add_annotation(input int depth);
		int n;
		add_random(2);
		n = pick_count(depth);
		add_count(n);
		repeat (n) begin
			add_random(2);
			add_value(depth);
		end
	endtask

	// Two pairs, the first opening a chain of two-element arrays; one frame
	// for the pair list plus one per array. Chains of 64 and more overflow.
	task automatic add_deep_chain(input int levels);
		add_random(2);
		add_count(2);
		add_random(2);
		repeat (levels) begin
			seq_bytes.push_back(TAG_ARRAY);
			add_count(2);
		end
		repeat (levels + 1) add_const();
		add_random(2);
		add_const();
	endtask

	// Pick start and limit around an annotation of len bytes.
	task automatic place_window(input int len, output logic [30:0] s, output logic [30:0] l);
		int mode;
		mode = $urandom_range(99);
		s    = 31'($urandom);
		if (mode < 50) begin
			l = s + 31'(len) + 31'($urandom_range(1, 8));
		end else if (mode < 70) begin
			l = s + 31'(len);                           // last byte just fits
		end else if (mode < 85) begin
			l = s + 31'($urandom_range(0, len - 1));    // runs out of bytes
		end else if (mode < 93) begin
			s = 31'h7FFFFFFF - 31'($urandom_range(0, 40));
			l = s + 31'(len);
		end else begin
			l = 31'($urandom);
		end
	endtask

	// Move the first upto bytes of seq_bytes into the feed, then clear it.
	task automatic queue_sequence(input logic [30:0] start, input logic [30:0] limit,
			input int upto, input bit lead, input bit drain);
		byte_item_t it;
		for (int i = 0; i < upto; i++) begin
			it.data  = seq_bytes[i];
			it.first = lead && (i == 0);
			it.start = (i == 0) ? start : 31'($urandom);
			it.limit = (i == 0) ? limit : 31'($urandom);
			it.drain = drain && (i == 0);
			byte_feed.push_back(it);
		end
		seq_bytes.delete();
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// Clock, cycle limit
	// ------------------------------------------------------------------------
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int          kind;
		int          upto;
		int          seq_count;
		int          stim_count;
		logic [30:0] s;
		logic [30:0] l;

		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		data_byte  = '0;
		first_byte = 1'b0;
		start_pos  = '0;
		limit_pos  = '0;
		out_stall  = 1'b0;

		// Directed: enum pair ending exactly at the top of the position range.
		seq_bytes = '{8'h11, 8'h22, 8'h00, 8'h01, 8'h33, 8'h44, TAG_ENUM,
			8'hFF, 8'h00, 8'hA5, 8'h5A};
		queue_sequence(31'h7FFFFFF4, 31'h7FFFFFFF, 11, 1'b1, 1'b0);
		// Start already at the limit: fails on the first byte.
		seq_bytes = '{8'hFF};
		queue_sequence(31'd0, 31'd0, 1, 1'b1, 1'b0);
		// Stray byte while idle: ignored.
		seq_bytes = '{8'h00};
		queue_sequence(31'h7FFFFFFF, 31'h7FFFFFFF, 1, 1'b0, 1'b0);
		// Empty array completes right after its count.
		seq_bytes = '{8'hAA, 8'hBB, 8'h00, 8'h01, 8'hCC, 8'hDD, TAG_ARRAY, 8'h00, 8'h00};
		queue_sequence(31'd100, 31'd200, 9, 1'b1, 1'b0);
		// Unknown tag.
		seq_bytes = '{8'h01, 8'h02, 8'h00, 8'h01, 8'h03, 8'h04, 8'hFF};
		queue_sequence(31'h1234, 31'h1266, 7, 1'b1, 1'b0);

		// Random: mostly well-formed annotations, some broken on purpose.
		seq_count  = 0;
		stim_count = 0;
		while (stim_count < BYTE_TARGET) begin
			kind = $urandom_range(99);
			if (kind < 5) begin
				add_random($urandom_range(1, 4));
				queue_sequence(31'($urandom), 31'($urandom), seq_bytes.size(), 1'b0, 1'b0);
			end else begin
				if (kind < 8)
					add_deep_chain($urandom_range(62, 65));
				else
					add_annotation(0);
				place_window(seq_bytes.size(), s, l);
				upto = seq_bytes.size();
				if (kind >= 8 && kind < 20)
					seq_bytes[$urandom_range(2, upto - 1)] = 8'($urandom);
				else if (kind >= 20 && kind < 28)
					upto = $urandom_range(1, upto - 1);   // next annotation restarts it
				stim_count += upto;
				queue_sequence(s, l, upto, 1'b1, (seq_count == 0) || ($urandom_range(99) < 4));
				seq_count++;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_feed.size() != 0 || expected_ends.size() != 0)
			@(posedge clk);
		// let any late result show up
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Byte driver: predict on acceptance at the rising edge, drive at the
	// falling edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : take_bytes
		walk_result_t res;
		if (in_valid && !in_stall) begin
			if (walk_annotation_byte(byte_feed[0], res))
				expected_ends.push_back(res);
			byte_feed.delete(0);
			accepted_count++;
			taken = 1'b1;
		end else begin
			taken = 1'b0;
		end
	end

	int send_gap  = 0;
	int send_calm = 0;

	always @(negedge clk) begin
		if (cycle_count >= 6) begin
			if (in_valid && !taken) begin
				// hold the stalled transaction as it is
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (byte_feed.size() == 0 ||
					(byte_feed[0].drain && expected_ends.size() != 0)) begin
				// nothing left, or pause until every result is in
				in_valid <= 1'b0;
			end else begin
				in_valid   <= 1'b1;
				data_byte  <= byte_feed[0].data;
				first_byte <= byte_feed[0].first;
				start_pos  <= byte_feed[0].start;
				limit_pos  <= byte_feed[0].limit;
				// maybe idle after this transaction, but never during calm stretches
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					if ($urandom_range(99) < 2)
						send_calm = 60;
					send_gap = pick_gap();
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result-side stall: random stalls, two long hold-offs while bytes keep
	// coming so the unit backs up and stalls its input.
	// ------------------------------------------------------------------------
	int stall_left = 0;
	int recv_calm  = 0;
	int hold_left  = 0;
	int holds_done = 0;

	always @(negedge clk) begin
		if ((holds_done == 0 && accepted_count >= 500) ||
				(holds_done == 1 && accepted_count >= 1200)) begin
			hold_left = 200;
			holds_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (recv_calm > 0)
				recv_calm--;
			else if ($urandom_range(99) < 2)
				recv_calm = 60;
			else if ($urandom_range(99) < 35)
				stall_left = pick_gap();
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: compare each accepted result with the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		walk_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_ends.size() == 0) begin
				$display("%0t: result expected none actual end_pos=%0h failed=%0b fail_reason=%0d",
					$time, end_pos, failed, fail_reason);
				mismatch_count++;
			end else begin
				want = expected_ends.pop_front();
				if (end_pos !== want.end_pos) begin
					$display("%0t: end_pos expected %0h actual %0h", $time, want.end_pos,
						end_pos);
					mismatch_count++;
				end
				if (failed !== want.failed) begin
					$display("%0t: failed expected %0b actual %0b", $time, want.failed, failed);
					mismatch_count++;
				end
				if (fail_reason !== want.reason) begin
					$display("%0t: fail_reason expected %0d actual %0d", $time, want.reason,
						fail_reason);
					mismatch_count++;
				end
			end
		end
	end

endmodule
